// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the integer to ASCII converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define I2A_ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define I2A_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define I2A_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define I2A_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/i2a_pkg.sv =====
// Shared types, constants and functions of the integer to ASCII converter.
`timescale 1ns / 1ps
package i2a_pkg;

  localparam int MAX_WIDTH = 48;
  localparam int VAL_W     = 64;
  localparam int BCD_DIGS  = 20;
  localparam int ACC_W     = 4 * BCD_DIGS;
  localparam int IDX_W     = 5;
  localparam int FLD_W     = 6;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_A_LO  = 8'h61;

  typedef enum logic [1:0] {
    BASE_OCT = 2'd0,
    BASE_DEC = 2'd1,
    BASE_HEX = 2'd2
  } base_t;

  typedef struct packed {
    logic load;
    logic step;
  } conv_ctl_t;

  function automatic logic [7:0] digit_ascii(input logic [3:0] d, input logic upper);
    logic [7:0] d8;
    d8 = {4'b0000, d};
    if (d < 4'd10) begin
      return CH_ZERO + d8;
    end else begin
      return (upper ? CH_A_UP : CH_A_LO) + d8 - 8'd10;
    end
  endfunction

endpackage

// ===== rtl/i2a_conv.sv =====
// Shift-and-add-three digit unit: builds BCD or raw binary digits one bit a cycle.
`timescale 1ns / 1ps
module i2a_conv import i2a_pkg::*; (
  input  logic                clk,
  input  conv_ctl_t           ctl,
  input  base_t               base,
  input  logic [VAL_W-1:0]    mag,
  input  logic [IDX_W-1:0]    rd_idx,
  output logic [3:0]          rd_digit
);

  logic [VAL_W-1:0] sh;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] adj;
  logic [127:0]     ext;
  logic [6:0]       hex_pos;
  logic [6:0]       oct_pos;

  always_comb begin
    for (int i = 0; i < BCD_DIGS; i++) begin
      if (base == BASE_DEC && acc[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = acc[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = acc[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sh  <= mag;
      acc <= '0;
    end else if (ctl.step) begin
      sh  <= {sh[VAL_W-2:0], 1'b0};
      acc <= {adj[ACC_W-2:0], sh[VAL_W-1]};
    end
  end

  assign ext     = {{(128-ACC_W){1'b0}}, acc};
  assign hex_pos = {rd_idx, 2'b00};
  assign oct_pos = {1'b0, rd_idx, 1'b0} + {2'b00, rd_idx};

  always_comb begin
    case (base)
      BASE_OCT: rd_digit = {1'b0, ext[oct_pos +: 3]};
      default:  rd_digit = ext[hex_pos +: 4];
    endcase
  end

endmodule

// ===== rtl/integer_to_padded_ascii.sv =====
// Sequence: the request is taken, the shift-and-add-three unit steps through all 64 bits,
// the leading-zero scan runs, then one character per cycle (up to 48) when not stalled.
// Requests: req_stall is high outside idle, so a new request waits until the last
// character of the field before it has been loaded into the output register.
// Reset: synchronous; the sequencer returns to idle and the output word is dropped.
`timescale 1ns / 1ps
module integer_to_padded_ascii import i2a_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  logic [63:0]      value,
  input  logic             is_signed,
  input  logic             is_wide,
  input  logic [1:0]       base_sel,
  input  logic             upper_case,
  input  logic             alt_form,
  input  logic [1:0]       sign_mode,
  input  logic [5:0]       min_width,
  input  logic             zero_pad,
  input  logic             left_adjust,
  output logic             chr_valid,
  input  logic             chr_stall,
  output logic [7:0]       char_out,
  output logic             last_char
);

`include "assert_macros.svh"

  localparam logic [1:0] SIGN_PLUS  = 2'd1;
  localparam logic [1:0] SIGN_SPACE = 2'd2;
  localparam logic [1:0] SEL_OCT    = 2'd0;
  localparam logic [1:0] SEL_DEC    = 2'd1;
  localparam logic [IDX_W-1:0] TOP_OCT = IDX_W'(21);
  localparam logic [IDX_W-1:0] TOP_DEC = IDX_W'(19);
  localparam logic [IDX_W-1:0] TOP_HEX = IDX_W'(15);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_CONV  = 10'b0000000010,
    ST_SCAN  = 10'b0000000100,
    ST_LEAD  = 10'b0000001000,
    ST_SIGN  = 10'b0000010000,
    ST_PFX0  = 10'b0000100000,
    ST_PFXX  = 10'b0001000000,
    ST_ZPAD  = 10'b0010000000,
    ST_DIGS  = 10'b0100000000,
    ST_TRAIL = 10'b1000000000
  } state_t;

  state_t            state, state_next;
  logic [5:0]        bit_cnt, bit_cnt_next;
  logic [IDX_W-1:0]  dig_idx, dig_idx_next;
  logic [FLD_W-1:0]  pad_left, pad_left_next;
  base_t             base;
  logic              upper;
  logic              has_sign;
  logic [7:0]        sign_ch;
  logic [1:0]        pfx_len;
  logic [FLD_W-1:0]  width_sat;
  logic              zp_eff;
  logic              left_adj;

  logic              accept;
  logic [63:0]       val_ext;
  logic              neg;
  logic [63:0]       mag;
  base_t             base_d;
  conv_ctl_t         conv_ctl;
  logic [3:0]        rd_digit;
  logic [IDX_W-1:0]  dig_top;
  logic [FLD_W-1:0]  content;
  logic [FLD_W-1:0]  pad_calc;
  logic [FLD_W-1:0]  pad_cur;
  logic              has_lead, has_p0, has_px, has_zpad, has_trail;
  state_t            after_zpad, after_px, after_p0, after_sign, after_lead;
  state_t            after_scan, after_digs;
  logic              load;
  logic [7:0]        char_next;
  logic              last_next;
  logic              pad_state;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != ST_IDLE);

  always_comb begin
    if (is_wide) begin
      val_ext = value;
    end else begin
      val_ext = {(is_signed && value[31]) ? 32'hFFFF_FFFF : 32'h0000_0000, value[31:0]};
    end
    neg = is_signed && val_ext[63];
    mag = neg ? (~val_ext + 64'd1) : val_ext;
    if (base_sel == SEL_OCT) begin
      base_d = BASE_OCT;
    end else if (base_sel == SEL_DEC) begin
      base_d = BASE_DEC;
    end else begin
      base_d = BASE_HEX;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      base      <= base_d;
      upper     <= upper_case;
      left_adj  <= left_adjust;
      zp_eff    <= zero_pad && !left_adjust;
      width_sat <= (min_width > FLD_W'(MAX_WIDTH)) ? FLD_W'(MAX_WIDTH) : min_width;
      has_sign  <= is_signed && (neg || sign_mode == SIGN_PLUS || sign_mode == SIGN_SPACE);
      if (neg) begin
        sign_ch <= CH_MINUS;
      end else if (sign_mode == SIGN_PLUS) begin
        sign_ch <= CH_PLUS;
      end else begin
        sign_ch <= CH_SPACE;
      end
      if (alt_form && val_ext != 64'd0 && base_d == BASE_OCT) begin
        pfx_len <= 2'd1;
      end else if (alt_form && val_ext != 64'd0 && base_d == BASE_HEX) begin
        pfx_len <= 2'd2;
      end else begin
        pfx_len <= 2'd0;
      end
    end
  end

  assign conv_ctl.load = accept;
  assign conv_ctl.step = (state == ST_CONV);

  i2a_conv u_conv (
    .clk      (clk),
    .ctl      (conv_ctl),
    .base     (base),
    .mag      (mag),
    .rd_idx   (dig_idx),
    .rd_digit (rd_digit)
  );

  always_comb begin
    case (base)
      BASE_OCT: dig_top = TOP_OCT;
      BASE_DEC: dig_top = TOP_DEC;
      default:  dig_top = TOP_HEX;
    endcase
  end

  assign content  = {1'b0, dig_idx} + FLD_W'(1) + {4'b0000, pfx_len}
                  + {{(FLD_W-1){1'b0}}, has_sign};
  assign pad_calc = (width_sat > content) ? (width_sat - content) : '0;
  assign pad_cur  = (state == ST_SCAN) ? pad_calc : pad_left;

  assign has_lead  = (pad_cur != '0) && !zp_eff && !left_adj;
  assign has_p0    = (pfx_len != 2'd0);
  assign has_px    = (pfx_len == 2'd2);
  assign has_zpad  = (pad_cur != '0) && zp_eff;
  assign has_trail = (pad_cur != '0) && left_adj;

  assign after_zpad = ST_DIGS;
  assign after_px   = has_zpad ? ST_ZPAD : after_zpad;
  assign after_p0   = has_px ? ST_PFXX : after_px;
  assign after_sign = has_p0 ? ST_PFX0 : after_p0;
  assign after_lead = has_sign ? ST_SIGN : after_sign;
  assign after_scan = has_lead ? ST_LEAD : after_lead;
  assign after_digs = has_trail ? ST_TRAIL : ST_IDLE;

  assign load = !chr_valid || !chr_stall;

  always_comb begin
    state_next    = state;
    bit_cnt_next  = bit_cnt;
    dig_idx_next  = dig_idx;
    pad_left_next = pad_left;
    char_next     = CH_SPACE;
    last_next     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next   = ST_CONV;
          bit_cnt_next = '0;
        end
      end
      ST_CONV: begin
        bit_cnt_next = bit_cnt + 6'd1;
        if (bit_cnt == 6'd63) begin
          state_next   = ST_SCAN;
          dig_idx_next = dig_top;
        end
      end
      ST_SCAN: begin
        if (rd_digit != 4'd0 || dig_idx == '0) begin
          state_next    = after_scan;
          pad_left_next = pad_calc;
        end else begin
          dig_idx_next = dig_idx - IDX_W'(1);
        end
      end
      ST_LEAD: begin
        char_next = CH_SPACE;
        if (load) begin
          pad_left_next = pad_left - FLD_W'(1);
          if (pad_left == FLD_W'(1)) begin
            state_next = after_lead;
          end
        end
      end
      ST_SIGN: begin
        char_next = sign_ch;
        if (load) begin
          state_next = after_sign;
        end
      end
      ST_PFX0: begin
        char_next = CH_ZERO;
        if (load) begin
          state_next = after_p0;
        end
      end
      ST_PFXX: begin
        char_next = upper ? CH_X_UP : CH_X_LO;
        if (load) begin
          state_next = after_px;
        end
      end
      ST_ZPAD: begin
        char_next = CH_ZERO;
        if (load) begin
          pad_left_next = pad_left - FLD_W'(1);
          if (pad_left == FLD_W'(1)) begin
            state_next = after_zpad;
          end
        end
      end
      ST_DIGS: begin
        char_next = digit_ascii(rd_digit, upper && base == BASE_HEX);
        last_next = (dig_idx == '0) && !has_trail;
        if (load) begin
          if (dig_idx == '0) begin
            state_next = after_digs;
          end else begin
            dig_idx_next = dig_idx - IDX_W'(1);
          end
        end
      end
      ST_TRAIL: begin
        char_next = CH_SPACE;
        last_next = (pad_left == FLD_W'(1));
        if (load) begin
          pad_left_next = pad_left - FLD_W'(1);
          if (pad_left == FLD_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  logic emitting;
  assign emitting = (state == ST_LEAD) || (state == ST_SIGN) || (state == ST_PFX0)
                 || (state == ST_PFXX) || (state == ST_ZPAD) || (state == ST_DIGS)
                 || (state == ST_TRAIL);

  assign pad_state = (state == ST_LEAD) || (state == ST_ZPAD) || (state == ST_TRAIL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      bit_cnt   <= '0;
      dig_idx   <= '0;
      pad_left  <= '0;
      chr_valid <= 1'b0;
    end else begin
      state    <= state_next;
      bit_cnt  <= bit_cnt_next;
      dig_idx  <= dig_idx_next;
      pad_left <= pad_left_next;
      if (emitting && load) begin
        chr_valid <= 1'b1;
      end else if (!chr_stall) begin
        chr_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emitting && load) begin
      char_out  <= char_next;
      last_char <= last_next;
    end
  end

  `I2A_ASSERT_NEXT(a_last_to_idle, clk, rst, emitting && load && last_next, state == ST_IDLE)
  `I2A_ASSERT_ALWAYS(a_pad_nonzero, clk, rst, !pad_state || pad_left != '0)
  `I2A_ASSERT_ALWAYS(a_digit_index, clk, rst, !(state == ST_DIGS) || dig_idx <= dig_top)

endmodule

// ===== test/integer_to_padded_ascii_tb.sv =====
// Self-checking testbench for integer_to_padded_ascii, with directed rows and random requests.
`timescale 1ns / 1ps
module integer_to_padded_ascii_tb;
  import i2a_pkg::*;

  localparam logic [1:0] BASE_SPARE = 2'd3;
  localparam logic [1:0] SIGN_NONE  = 2'd0;
  localparam logic [1:0] SIGN_PLUS  = 2'd1;
  localparam logic [1:0] SIGN_SPACE = 2'd2;
  localparam logic [1:0] SIGN_SPARE = 2'd3;
  localparam int RANDOM_REQUESTS = 244;

  typedef struct packed {
    logic [63:0] value;
    logic        is_signed;
    logic        is_wide;
    logic [1:0]  base_sel;
    logic        upper_case;
    logic        alt_form;
    logic [1:0]  sign_mode;
    logic [5:0]  min_width;
    logic        zero_pad;
    logic        left_adjust;
  } conv_req_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } field_char_t;

  typedef logic [7:0] char_q_t[$];

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [63:0] value = '0;
  logic        is_signed = 1'b0;
  logic        is_wide = 1'b0;
  logic [1:0]  base_sel = '0;
  logic        upper_case = 1'b0;
  logic        alt_form = 1'b0;
  logic [1:0]  sign_mode = '0;
  logic [5:0]  min_width = '0;
  logic        zero_pad = 1'b0;
  logic        left_adjust = 1'b0;
  logic        chr_valid;
  logic        chr_stall = 1'b0;
  logic [7:0]  char_out;
  logic        last_char;

  field_char_t pending_chars[$];
  conv_req_t   stim_rows[$];
  string       stim_texts[$];
  int          mismatches = 0;
  bit          no_idle = 1'b0;

  integer_to_padded_ascii DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .value(value), .is_signed(is_signed), .is_wide(is_wide), .base_sel(base_sel),
    .upper_case(upper_case), .alt_form(alt_form), .sign_mode(sign_mode),
    .min_width(min_width), .zero_pad(zero_pad), .left_adjust(left_adjust),
    .chr_valid(chr_valid), .chr_stall(chr_stall),
    .char_out(char_out), .last_char(last_char)
  );

  always #5 clk = ~clk;

  function automatic char_q_t format_field(input conv_req_t r);
    logic [63:0] v, mag, radix, d;
    logic [7:0]  sgn;
    char_q_t     digs, res;
    int          wid, pfx, pad;
    bit          zp;
    wid = (r.min_width > MAX_WIDTH) ? MAX_WIDTH : int'(r.min_width);
    v = r.value;
    if (!r.is_wide) begin
      v = r.is_signed ? {{32{v[31]}}, v[31:0]} : {32'b0, v[31:0]};
    end
    mag = v;
    sgn = 8'd0;
    if (r.is_signed) begin
      if (v[63]) begin
        mag = ~v + 64'd1;
        sgn = CH_MINUS;
      end else if (r.sign_mode == SIGN_PLUS) begin
        sgn = CH_PLUS;
      end else if (r.sign_mode == SIGN_SPACE) begin
        sgn = CH_SPACE;
      end
    end
    case (r.base_sel)
      BASE_OCT: radix = 64'd8;
      BASE_DEC: radix = 64'd10;
      default:  radix = 64'd16;
    endcase
    pfx = 0;
    if (r.alt_form && mag != 0) begin
      pfx = (radix == 64'd8) ? 1 : (radix == 64'd16) ? 2 : 0;
    end
    do begin
      d = mag % radix;
      if (d < 10) begin
        digs.push_front(CH_ZERO + d[7:0]);
      end else begin
        digs.push_front((r.upper_case ? CH_A_UP : CH_A_LO) + d[7:0] - 8'd10);
      end
      mag = mag / radix;
    end while (mag != 0);
    pad = wid - (digs.size() + pfx + ((sgn != 0) ? 1 : 0));
    if (pad < 0) pad = 0;
    zp = r.zero_pad && !r.left_adjust;
    if (!zp && !r.left_adjust) repeat (pad) res.push_back(CH_SPACE);
    if (sgn != 0) res.push_back(sgn);
    if (pfx >= 1) res.push_back(CH_ZERO);
    if (pfx == 2) res.push_back(r.upper_case ? CH_X_UP : CH_X_LO);
    if (zp) repeat (pad) res.push_back(CH_ZERO);
    foreach (digs[i]) res.push_back(digs[i]);
    if (r.left_adjust) repeat (pad) res.push_back(CH_SPACE);
    return res;
  endfunction

  task automatic row(input logic [63:0] v, input logic sgd, input logic wide,
                     input logic [1:0] base, input logic upper, input logic alt,
                     input logic [1:0] smode, input logic [5:0] wid, input logic zp,
                     input logic la, input string text);
    stim_rows.push_back({v, sgd, wide, base, upper, alt, smode, wid, zp, la});
    stim_texts.push_back(text);
  endtask

  task automatic send_request(input conv_req_t r, input string text);
    char_q_t chars;
    while (!no_idle && $urandom_range(99) < 17) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    {value, is_signed, is_wide, base_sel, upper_case, alt_form, sign_mode,
     min_width, zero_pad, left_adjust} <= r;
    do @(posedge clk); while (req_stall);
    if (text.len() != 0) begin
      for (int i = 0; i < text.len(); i++) chars.push_back(text[i]);
    end else begin
      chars = format_field(r);
    end
    foreach (chars[i]) pending_chars.push_back({chars[i], i == chars.size() - 1});
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_chars.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      chr_stall <= 1'b0;
    end else begin
      if (chr_valid && !chr_stall) begin
        if (pending_chars.size() == 0) begin
          $display("%0t: unexpected word char_out=%h last_char=%b", $time, char_out,
                   last_char);
          mismatches++;
        end else begin
          if (char_out !== pending_chars[0].ch) begin
            $display("%0t: char_out expected %h actual %h", $time, pending_chars[0].ch,
                     char_out);
            mismatches++;
          end
          if (last_char !== pending_chars[0].last) begin
            $display("%0t: last_char expected %b actual %b", $time, pending_chars[0].last,
                     last_char);
            mismatches++;
          end
          void'(pending_chars.pop_front());
        end
      end
      chr_stall <= !no_idle && ($urandom_range(99) < 17);
    end
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    conv_req_t r;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    row(64'd0, 0, 0, BASE_DEC, 0, 0, SIGN_NONE, 6'd0, 0, 0, "0");
    row(64'd0, 1, 0, BASE_HEX, 0, 1, SIGN_NONE, 6'd0, 0, 0, "0");
    row(64'h0000_0000_FFFF_FFFF, 0, 0, BASE_DEC, 0, 0, SIGN_PLUS, 6'd0, 0, 0, "4294967295");
    row(64'h0000_0000_FFFF_FFFF, 1, 0, BASE_DEC, 0, 0, SIGN_NONE, 6'd0, 0, 0, "-1");
    row(64'h8000_0000_0000_0000, 1, 1, BASE_DEC, 0, 0, SIGN_NONE, 6'd0, 0, 0,
        "-9223372036854775808");
    row(64'hFFFF_FFFF_FFFF_FFFF, 0, 1, BASE_OCT, 0, 0, SIGN_NONE, 6'd0, 0, 0,
        "1777777777777777777777");
    row(64'hFFFF_FFFF_FFFF_FFFF, 0, 1, BASE_HEX, 1, 1, SIGN_NONE, 6'd0, 0, 0,
        "0XFFFFFFFFFFFFFFFF");
    row(64'h0000_0000_8000_0000, 1, 0, BASE_HEX, 0, 0, SIGN_NONE, 6'd0, 0, 0, "-80000000");
    row(64'd255, 0, 0, BASE_HEX, 0, 1, SIGN_NONE, 6'd0, 0, 0, "0xff");
    row(64'd8, 0, 0, BASE_OCT, 0, 1, SIGN_NONE, 6'd0, 0, 0, "010");
    row(64'd42, 1, 0, BASE_DEC, 0, 0, SIGN_PLUS, 6'd0, 0, 0, "+42");
    row(64'd42, 1, 1, BASE_DEC, 0, 0, SIGN_SPACE, 6'd0, 0, 0, " 42");
    row(64'd42, 1, 0, BASE_DEC, 0, 0, SIGN_SPARE, 6'd0, 0, 0, "42");
    row(64'd42, 0, 0, BASE_DEC, 0, 0, SIGN_PLUS, 6'd0, 0, 0, "42");
    row(64'd255, 0, 0, BASE_SPARE, 0, 0, SIGN_NONE, 6'd0, 0, 0, "ff");
    row(64'd255, 0, 0, BASE_DEC, 1, 1, SIGN_NONE, 6'd0, 0, 0, "255");
    row(64'd7, 0, 0, BASE_DEC, 0, 0, SIGN_NONE, 6'd5, 0, 0, "    7");
    row(64'd7, 0, 0, BASE_DEC, 0, 0, SIGN_NONE, 6'd5, 1, 0, "00007");
    row(64'd7, 0, 0, BASE_DEC, 0, 0, SIGN_NONE, 6'd5, 1, 1, "7    ");
    row(64'h0000_0000_FFFF_FFFB, 1, 0, BASE_DEC, 0, 0, SIGN_NONE, 6'd6, 1, 0, "-00005");
    row(64'd255, 0, 0, BASE_HEX, 0, 1, SIGN_NONE, 6'd8, 1, 0, "0x0000ff");
    row(64'd12345, 0, 0, BASE_DEC, 0, 0, SIGN_NONE, 6'd3, 0, 0, "12345");
    row(64'hDEAD_BEEF_0000_0010, 0, 0, BASE_DEC, 0, 0, SIGN_NONE, 6'd0, 0, 0, "16");
    row(64'd1, 0, 0, BASE_DEC, 0, 0, SIGN_NONE, 6'd63, 0, 0, "");
    row(64'd1, 1, 0, BASE_DEC, 0, 0, SIGN_PLUS, 6'd48, 0, 1, "");
    row(64'h1234_5678_9ABC_DEF0, 1, 1, BASE_HEX, 1, 1, SIGN_SPACE, 6'd40, 1, 0, "");

    foreach (stim_rows[i]) send_request(stim_rows[i], stim_texts[i]);
    wait_drained();

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      no_idle = (i >= 100 && i < 160);
      if (i == 200) wait_drained();
      case ($urandom_range(0, 5))
        0: r.value = 64'($urandom_range(0, 999));
        1: r.value = {$urandom, $urandom};
        2: r.value = {32'($urandom), 32'($urandom)} >> $urandom_range(0, 63);
        3: r.value = 64'd1 << $urandom_range(0, 63);
        4: begin
          case ($urandom_range(0, 4))
            0: r.value = 64'd0;
            1: r.value = '1;
            2: r.value = 64'h8000_0000_0000_0000;
            3: r.value = 64'h7FFF_FFFF_FFFF_FFFF;
            default: r.value = {32'($urandom), 32'h8000_0000};
          endcase
        end
        default: r.value = {32'($urandom), 32'($urandom)};
      endcase
      r.is_signed   = 1'($urandom);
      r.is_wide     = 1'($urandom);
      r.base_sel    = 2'($urandom_range(0, 3));
      r.upper_case  = 1'($urandom);
      r.alt_form    = 1'($urandom);
      r.sign_mode   = 2'($urandom_range(0, 3));
      r.min_width   = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                                   : 6'($urandom_range(0, 24));
      r.zero_pad    = 1'($urandom);
      r.left_adjust = 1'($urandom);
      send_request(r, "");
    end
    no_idle = 1'b0;
    wait_drained();
    repeat (150) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/i2a_pkg.sv
rtl/i2a_conv.sv
rtl/integer_to_padded_ascii.sv
test/integer_to_padded_ascii_tb.sv
